// File: rtl/multi_pattern_substring_matcher_top_defines.svh
// Assertion macros for the matcher checker
`ifndef MULTI_PATTERN_SUBSTRING_MATCHER_TOP_DEFINES_SVH
`define MULTI_PATTERN_SUBSTRING_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MPSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpsm check failed");

// next-cycle implication, disabled while in reset
`define MPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpsm check failed");

`endif

// File: rtl/mpsm_pkg.sv
// Constants, types and helpers for the multi-pattern substring matcher
`default_nettype none
package mpsm_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_NODES     = 256;
    localparam int MAX_PATTERNS  = 64;

    localparam int CMD_W       = 2;
    localparam int LTR_W       = 5;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NCNT_W      = $clog2(MAX_NODES + 1);
    localparam int PAT_W       = $clog2(MAX_PATTERNS);
    localparam int PCNT_W      = $clog2(MAX_PATTERNS + 1);
    localparam int CHILD_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PAT_LTR  = 2'd0,
        CMD_PAT_END  = 2'd1,
        CMD_TEXT_LTR = 2'd2,
        CMD_TEXT_END = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_DO,
        ST_BLD_INIT,
        ST_BLD_POP,
        ST_BLD_POPW,
        ST_BLD_FU,
        ST_BLD_CRD,
        ST_BLD_CHK,
        ST_RES_RD,
        ST_RES_CHK,
        ST_RES_FW,
        ST_TXT_START,
        ST_PRP_NODE,
        ST_PRP_CHK,
        ST_PRP_FW,
        ST_RPT_RD,
        ST_RPT_LOAD,
        ST_RPT_MARK,
        ST_RPT_OUT
    } t_state;

    // flat address of one child slot: node row times alphabet plus letter
    function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                       input logic [LTR_W-1:0]  ltr);
        return CHILD_AW'(CHILD_AW'(node) * CHILD_AW'(ALPHABET_SIZE)) + CHILD_AW'(ltr);
    endfunction

endpackage
`default_nettype wire

// File: rtl/mpsm_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/multi_pattern_substring_matcher_top.sv
// Top level of the multi-pattern substring matcher (Aho-Corasick automaton)
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------------
//  input   | i_valid / o_stall  | i_command, i_letter
//  output  | o_valid / i_stall  | o_pattern_number, o_found, o_table_overflow,
//          |                    | o_last_of_report
//
// A pattern end is taken in the idle state; a pattern letter reads the child memory,
// then writes it if the child is new. The first text item builds the failure links
// breadth-first; each text letter follows failure links from the current state. End
// of text marks every node on the link chain of each reached node, then gives one
// result per pattern. Reset and each end of text start a sweep zeroing the child and
// mark memories; no transaction is accepted during it. Results wait in an output
// register under stall.
`default_nettype none
module multi_pattern_substring_matcher_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [mpsm_pkg::CMD_W-1:0]  i_command,
    input  wire logic [mpsm_pkg::LTR_W-1:0]  i_letter,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [mpsm_pkg::PAT_W-1:0]  o_pattern_number,
    output logic                             o_found,
    output logic                             o_table_overflow,
    output logic                             o_last_of_report
);
    import mpsm_pkg::*;

    t_state                r_state, n_state;
    logic [CHILD_AW-1:0]   r_clr_addr, n_clr_addr;
    t_cmd                  r_cmd, n_cmd;
    logic [LTR_W-1:0]      r_letter, n_letter;
    logic [NCNT_W-1:0]     r_node_cnt, n_node_cnt;
    logic [PCNT_W-1:0]     r_pat_cnt, n_pat_cnt;
    logic [NODE_W-1:0]     r_cursor, n_cursor;
    logic [NODE_W-1:0]     r_scan, n_scan;
    logic                  r_built, n_built;
    logic                  r_ovf, n_ovf;
    logic [NCNT_W-1:0]     r_head, n_head;
    logic [NCNT_W-1:0]     r_tail, n_tail;
    logic [NODE_W-1:0]     r_u, n_u;
    logic [NODE_W-1:0]     r_fu, n_fu;
    logic [LTR_W-1:0]      r_c, n_c;
    logic [NODE_W-1:0]     r_v, n_v;
    logic [NODE_W-1:0]     r_f, n_f;
    logic [NCNT_W-1:0]     r_i, n_i;
    logic [PCNT_W-1:0]     r_k, n_k;
    logic                  r_out_vld, n_out_vld;
    logic [PAT_W-1:0]      r_out_num, n_out_num;
    logic                  r_out_found, n_out_found;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    // memory ports
    logic                  child_we;
    logic [CHILD_AW-1:0]   child_waddr, child_raddr;
    logic [NODE_W-1:0]     child_wdata, child_rdata;
    logic                  fail_we;
    logic [NODE_W-1:0]     fail_waddr, fail_wdata, fail_raddr, fail_rdata;
    logic                  q_we;
    logic [NODE_W-1:0]     q_waddr, q_wdata, q_raddr, q_rdata;
    logic                  pen_we;
    logic [PAT_W-1:0]      pen_waddr, pen_raddr;
    logic [NODE_W-1:0]     pen_wdata, pen_rdata;
    logic                  mark_we;
    logic [NODE_W-1:0]     mark_waddr, mark_raddr;
    logic                  mark_wdata, mark_rdata;

    logic accept;
    logic in_ltr_ok;
    logic ltr_ok;
    logic last_ltr;
    logic res_done;
    logic q_empty;
    logic prp_end;
    logic prp_walk;
    logic job_done;

    assign o_stall   = (r_state != ST_IDLE);
    assign accept    = i_valid && !o_stall;
    assign in_ltr_ok = (i_letter < LTR_W'(ALPHABET_SIZE));
    assign ltr_ok    = (r_letter < LTR_W'(ALPHABET_SIZE));
    assign last_ltr  = (r_c == LTR_W'(ALPHABET_SIZE - 1));
    // walk stops at the root or where the child exists
    assign res_done  = (r_f == '0) || (child_rdata != '0);
    assign q_empty   = (r_head == r_tail);
    assign prp_end   = (r_i >= r_node_cnt);
    // marked node with a non-root link starts a chain walk
    assign prp_walk  = mark_rdata && (fail_rdata != '0);
    assign job_done  = ((r_state == ST_PRP_NODE) && prp_end && (r_pat_cnt == '0)) ||
                       ((r_state == ST_RPT_OUT) && !i_stall && r_out_last);

    mpsm_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
        .i_clk  (i_clk),
        .i_we   (child_we),
        .i_waddr(child_waddr),
        .i_wdata(child_wdata),
        .i_raddr(child_raddr),
        .o_rdata(child_rdata)
    );

    mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .i_clk  (i_clk),
        .i_we   (fail_we),
        .i_waddr(fail_waddr),
        .i_wdata(fail_wdata),
        .i_raddr(fail_raddr),
        .o_rdata(fail_rdata)
    );

    mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_PATTERNS)) u_pend (
        .i_clk  (i_clk),
        .i_we   (pen_we),
        .i_waddr(pen_waddr),
        .i_wdata(pen_wdata),
        .i_raddr(pen_raddr),
        .o_rdata(pen_rdata)
    );

    mpsm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
        .i_clk  (i_clk),
        .i_we   (mark_we),
        .i_waddr(mark_waddr),
        .i_wdata(mark_wdata),
        .i_raddr(mark_raddr),
        .o_rdata(mark_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CHILD_AW'(CHILD_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_PAT_LTR: begin
                            if (!r_built && in_ltr_ok) n_state = ST_LOAD_DO;
                        end
                        CMD_PAT_END: n_state = ST_IDLE;
                        CMD_TEXT_LTR, CMD_TEXT_END: begin
                            n_state = r_built ? ST_TXT_START : ST_BLD_INIT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_DO:  n_state = ST_IDLE;
            ST_BLD_INIT: n_state = ST_BLD_POP;
            ST_BLD_POP:  n_state = q_empty ? ST_TXT_START : ST_BLD_POPW;
            ST_BLD_POPW: n_state = ST_BLD_FU;
            ST_BLD_FU:   n_state = ST_BLD_CRD;
            ST_BLD_CRD:  n_state = ST_BLD_CHK;
            ST_BLD_CHK: begin
                if (child_rdata != '0 && r_u != '0) n_state = ST_RES_RD;
                else n_state = last_ltr ? ST_BLD_POP : ST_BLD_CRD;
            end
            ST_RES_RD: n_state = ST_RES_CHK;
            ST_RES_CHK: begin
                if (!res_done) n_state = ST_RES_FW;
                else if (!r_built) n_state = last_ltr ? ST_BLD_POP : ST_BLD_CRD;
                else n_state = ST_IDLE;
            end
            ST_RES_FW: n_state = ST_RES_RD;
            ST_TXT_START: begin
                if (r_cmd == CMD_TEXT_LTR) n_state = ltr_ok ? ST_RES_RD : ST_IDLE;
                else n_state = ST_PRP_NODE;
            end
            ST_PRP_NODE: begin
                if (prp_end) n_state = (r_pat_cnt == '0) ? ST_CLEAR : ST_RPT_RD;
                else n_state = ST_PRP_CHK;
            end
            ST_PRP_CHK: n_state = prp_walk ? ST_PRP_FW : ST_PRP_NODE;
            ST_PRP_FW: begin
                if (fail_rdata == '0) n_state = ST_PRP_NODE;
            end
            ST_RPT_RD:   n_state = ST_RPT_LOAD;
            ST_RPT_LOAD: n_state = ST_RPT_MARK;
            ST_RPT_MARK: n_state = ST_RPT_OUT;
            ST_RPT_OUT: begin
                if (!i_stall) n_state = r_out_last ? ST_CLEAR : ST_RPT_RD;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_letter    = r_letter;
        n_node_cnt  = r_node_cnt;
        n_pat_cnt   = r_pat_cnt;
        n_cursor    = r_cursor;
        n_scan      = r_scan;
        n_built     = r_built;
        n_ovf       = r_ovf;
        n_head      = r_head;
        n_tail      = r_tail;
        n_u         = r_u;
        n_fu        = r_fu;
        n_c         = r_c;
        n_v         = r_v;
        n_f         = r_f;
        n_i         = r_i;
        n_k         = r_k;
        n_out_vld   = r_out_vld;
        n_out_num   = r_out_num;
        n_out_found = r_out_found;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;

        child_we    = 1'b0;
        child_waddr = child_addr(r_cursor, r_letter);
        child_wdata = '0;
        child_raddr = child_addr(r_f, r_c);
        fail_we     = 1'b0;
        fail_waddr  = r_v;
        fail_wdata  = child_rdata;
        fail_raddr  = r_f;
        q_we        = 1'b0;
        q_waddr     = r_tail[NODE_W-1:0];
        q_wdata     = r_v;
        q_raddr     = r_head[NODE_W-1:0];
        pen_we      = 1'b0;
        pen_waddr   = r_pat_cnt[PAT_W-1:0];
        pen_wdata   = r_cursor;
        pen_raddr   = r_k[PAT_W-1:0];
        mark_we     = 1'b0;
        mark_waddr  = child_rdata;
        mark_wdata  = 1'b1;
        mark_raddr  = r_i[NODE_W-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_clr_addr;
                child_wdata = '0;
                mark_we     = 1'b1;
                mark_waddr  = r_clr_addr[NODE_W-1:0];
                mark_wdata  = 1'b0;
                n_clr_addr  = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd    = t_cmd'(i_command);
                    n_letter = i_letter;
                    if (t_cmd'(i_command) == CMD_PAT_LTR) begin
                        child_raddr = child_addr(r_cursor, i_letter);
                    end else if (t_cmd'(i_command) == CMD_PAT_END && !r_built) begin
                        if (r_pat_cnt >= PCNT_W'(MAX_PATTERNS)) begin
                            n_ovf = 1'b1;
                        end else begin
                            pen_we    = 1'b1;
                            n_pat_cnt = r_pat_cnt + 1'b1;
                        end
                        n_cursor = '0;
                    end
                end
            end
            ST_LOAD_DO: begin
                if (child_rdata != '0) begin
                    n_cursor = child_rdata;
                end else if (r_node_cnt >= NCNT_W'(MAX_NODES)) begin
                    n_ovf = 1'b1;
                end else begin
                    child_we    = 1'b1;
                    child_wdata = r_node_cnt[NODE_W-1:0];
                    n_cursor    = r_node_cnt[NODE_W-1:0];
                    n_node_cnt  = r_node_cnt + 1'b1;
                end
            end
            ST_BLD_INIT: begin
                // root goes in first; its children get the root as link
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '0;
                n_head  = '0;
                n_tail  = NCNT_W'(1);
            end
            ST_BLD_POP: begin
                if (q_empty) begin
                    n_built    = 1'b1;
                    mark_we    = 1'b1;
                    mark_waddr = '0;
                end else begin
                    n_head = r_head + 1'b1;
                end
            end
            ST_BLD_POPW: begin
                n_u        = q_rdata;
                fail_raddr = q_rdata;
            end
            ST_BLD_FU: begin
                n_fu = fail_rdata;
                n_c  = '0;
            end
            ST_BLD_CRD: begin
                child_raddr = child_addr(r_u, r_c);
            end
            ST_BLD_CHK: begin
                if (child_rdata != '0 && r_u != '0) begin
                    n_v = child_rdata;
                    n_f = r_fu;
                end else begin
                    if (child_rdata != '0) begin
                        fail_we    = 1'b1;
                        fail_waddr = child_rdata;
                        fail_wdata = '0;
                        q_we       = 1'b1;
                        q_wdata    = child_rdata;
                        n_tail     = r_tail + 1'b1;
                    end
                    n_c = r_c + 1'b1;
                end
            end
            ST_RES_RD: begin
                child_raddr = child_addr(r_f, r_c);
            end
            ST_RES_CHK: begin
                if (!res_done) begin
                    fail_raddr = r_f;
                end else if (!r_built) begin
                    fail_we = 1'b1;
                    q_we    = 1'b1;
                    n_tail  = r_tail + 1'b1;
                    n_c     = r_c + 1'b1;
                end else begin
                    n_scan  = child_rdata;
                    mark_we = 1'b1;
                end
            end
            ST_RES_FW: begin
                n_f = fail_rdata;
            end
            ST_TXT_START: begin
                if (r_cmd == CMD_TEXT_LTR) begin
                    if (ltr_ok) begin
                        n_f = r_scan;
                        n_c = r_letter;
                    end else begin
                        n_scan     = '0;
                        mark_we    = 1'b1;
                        mark_waddr = '0;
                    end
                end else begin
                    // the root's chain is empty, so the walk starts at node 1
                    n_i = NCNT_W'(1);
                end
            end
            ST_PRP_NODE: begin
                if (prp_end) begin
                    n_k = '0;
                end else begin
                    fail_raddr = r_i[NODE_W-1:0];
                    mark_raddr = r_i[NODE_W-1:0];
                    n_i        = r_i + 1'b1;
                end
            end
            ST_PRP_CHK: begin
                if (prp_walk) begin
                    mark_we    = 1'b1;
                    mark_waddr = fail_rdata;
                    fail_raddr = fail_rdata;
                end
            end
            ST_PRP_FW: begin
                fail_raddr = fail_rdata;
                if (fail_rdata != '0) begin
                    mark_we    = 1'b1;
                    mark_waddr = fail_rdata;
                end
            end
            ST_RPT_RD: begin
                pen_raddr = r_k[PAT_W-1:0];
            end
            ST_RPT_LOAD: begin
                mark_raddr = pen_rdata;
            end
            ST_RPT_MARK: begin
                n_out_vld   = 1'b1;
                n_out_num   = r_k[PAT_W-1:0];
                n_out_found = mark_rdata;
                n_out_ovf   = r_ovf;
                n_out_last  = ((r_k + 1'b1) == r_pat_cnt);
            end
            ST_RPT_OUT: begin
                if (!i_stall) begin
                    n_out_vld = 1'b0;
                    n_k       = r_k + 1'b1;
                end
            end
            default: begin
                n_clr_addr = '0;
            end
        endcase

        // end of job: back to the reset state, sweep follows
        if (job_done) begin
            n_clr_addr = '0;
            n_node_cnt = NCNT_W'(1);
            n_pat_cnt  = '0;
            n_cursor   = '0;
            n_scan     = '0;
            n_built    = 1'b0;
            n_ovf      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_node_cnt <= NCNT_W'(1);
            r_pat_cnt  <= '0;
            r_cursor   <= '0;
            r_scan     <= '0;
            r_built    <= 1'b0;
            r_ovf      <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_i        <= '0;
            r_k        <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_node_cnt <= n_node_cnt;
            r_pat_cnt  <= n_pat_cnt;
            r_cursor   <= n_cursor;
            r_scan     <= n_scan;
            r_built    <= n_built;
            r_ovf      <= n_ovf;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_i        <= n_i;
            r_k        <= n_k;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_letter    <= n_letter;
        r_u         <= n_u;
        r_fu        <= n_fu;
        r_c         <= n_c;
        r_v         <= n_v;
        r_f         <= n_f;
        r_out_num   <= n_out_num;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_valid          = r_out_vld;
    assign o_pattern_number = r_out_num;
    assign o_found          = r_out_found;
    assign o_table_overflow = r_out_ovf;
    assign o_last_of_report = r_out_last;

endmodule
`default_nettype wire

// File: rtl/mpsm_checker.sv
// Port-level checker for the matcher, bound to the top level
`default_nettype none
`include "multi_pattern_substring_matcher_top_defines.svh"
module mpsm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [mpsm_pkg::PAT_W-1:0]  o_pattern_number,
    input wire logic                        o_found,
    input wire logic                        o_table_overflow,
    input wire logic                        o_last_of_report
);
    // no input transaction while a result is pending
    `MPSM_ASSERT_NOW(a_no_accept_in_report, o_valid, o_stall)
    // o_valid drops after each taken result while the next memory read runs
    `MPSM_ASSERT_NEXT(a_gap_after_result, o_valid && !i_stall, !o_valid)
    // after the final result the block sweeps memory and holds off input
    `MPSM_ASSERT_NEXT(a_sweep_after_last, o_valid && !i_stall && o_last_of_report, o_stall)
    // stalled result holds
    `MPSM_ASSERT_NEXT(a_hold_stalled, o_valid && i_stall, o_valid && $stable(o_pattern_number) && $stable(o_found) && $stable(o_table_overflow) && $stable(o_last_of_report))
endmodule

bind multi_pattern_substring_matcher_top mpsm_checker u_mpsm_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the multi-pattern substring matcher top level
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mpsm_pkg::*;

    typedef struct {
        int unsigned pattern_number;
        bit          found;
        bit          overflow;
        bit          last;
    } t_match_flag;

    // Aho-Corasick automaton kept alongside the block
    class match_scoreboard;
        int unsigned child[MAX_NODES*ALPHABET_SIZE];
        int unsigned fail_link[MAX_NODES];
        int unsigned bfs[MAX_NODES];
        bit          reached[MAX_NODES];
        int unsigned end_node[MAX_PATTERNS];
        int unsigned node_cnt, pat_cnt, cursor, scan, ovf;
        bit          built;
        t_match_flag pending_flags[$];

        function void clear_trie();
            foreach (child[i]) child[i] = 0;
            foreach (fail_link[i]) fail_link[i] = 0;
            foreach (bfs[i]) bfs[i] = 0;
            foreach (reached[i]) reached[i] = 0;
            foreach (end_node[i]) end_node[i] = 0;
            node_cnt = 1;
            pat_cnt  = 0;
            cursor   = 0;
            scan     = 0;
            built    = 0;
            ovf      = 0;
        endfunction

        function int unsigned child_of(int unsigned node, int unsigned c);
            if (node >= MAX_NODES || c >= ALPHABET_SIZE) return 0;
            return child[node*ALPHABET_SIZE + c];
        endfunction

        function int unsigned fail_of(int unsigned node);
            if (node >= MAX_NODES) return 0;
            return fail_link[node];
        endfunction

        function void build_links();
            int unsigned head, tail, u, v, f;
            head = 0;
            tail = 0;
            fail_link[0] = 0;
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
                v = child_of(0, c);
                if (v != 0 && tail < MAX_NODES) begin
                    fail_link[v] = 0;
                    bfs[tail++] = v;
                end
            end
            while (head < tail) begin
                u = bfs[head++];
                for (int c = 0; c < ALPHABET_SIZE; c++) begin
                    v = child_of(u, c);
                    if (v == 0 || v >= MAX_NODES) continue;
                    f = fail_of(u);
                    while (f != 0 && child_of(f, c) == 0) f = fail_of(f);
                    fail_link[v] = child_of(f, c);
                    if (tail < MAX_NODES) bfs[tail++] = v;
                end
            end
            reached[0] = 1;
            built = 1;
        endfunction

        function void note_input(t_cmd cmd, int unsigned c);
            int unsigned n, f, guard;
            t_match_flag r;
            if (cmd == CMD_PAT_LTR) begin
                if (built || c >= ALPHABET_SIZE) return;
                n = child_of(cursor, c);
                if (n == 0) begin
                    if (node_cnt >= MAX_NODES) begin
                        ovf = 1;
                        return;
                    end
                    n = node_cnt++;
                    child[cursor*ALPHABET_SIZE + c] = n;
                end
                cursor = n;
                return;
            end
            if (cmd == CMD_PAT_END) begin
                if (built) return;
                if (pat_cnt >= MAX_PATTERNS) ovf = 1;
                else end_node[pat_cnt++] = cursor;
                cursor = 0;
                return;
            end
            if (!built) build_links();
            if (cmd == CMD_TEXT_LTR) begin
                if (c >= ALPHABET_SIZE) n = 0;
                else begin
                    n = scan;
                    while (n != 0 && child_of(n, c) == 0) n = fail_of(n);
                    n = child_of(n, c);
                end
                scan = n;
                reached[n] = 1;
                return;
            end
            for (int unsigned i = 0; i < node_cnt && i < MAX_NODES; i++) begin
                if (reached[i]) begin
                    f = fail_of(i);
                    guard = 0;
                    while (f != 0 && guard < MAX_NODES) begin
                        reached[f] = 1;
                        f = fail_of(f);
                        guard++;
                    end
                end
            end
            for (int unsigned i = 0; i < pat_cnt; i++) begin
                r.pattern_number = i & 63;
                r.found          = reached[end_node[i]];
                r.overflow       = ovf[0];
                r.last           = (i + 1 == pat_cnt);
                pending_flags.insert(pending_flags.size(), r);
            end
            clear_trie();
        endfunction

        function bit check_result(int unsigned pn, bit fd, bit ov, bit lst,
                                  output string msg);
            t_match_flag e;
            if (pending_flags.size() == 0) begin
                msg = $sformatf("unexpected result pattern %0d", pn);
                return 0;
            end
            e = pending_flags.pop_front();
            if (e.pattern_number != pn || e.found != fd || e.overflow != ov
                    || e.last != lst) begin
                msg = $sformatf("pattern %0d/%0d found %0d/%0d ovf %0d/%0d last %0d/%0d",
                                pn, e.pattern_number, fd, e.found, ov, e.overflow,
                                lst, e.last);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [CMD_W-1:0] i_command;
    logic [LTR_W-1:0] i_letter;
    logic             o_valid;
    logic             i_stall;
    logic [PAT_W-1:0] o_pattern_number;
    logic             o_found;
    logic             o_table_overflow;
    logic             o_last_of_report;

    multi_pattern_substring_matcher_top dut (.*);

    match_scoreboard sb;
    int errors    = 0;
    int items     = 0;
    int gap_pct   = 0;
    int stall_pct = 0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 3000000;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            if (!sb.check_result(o_pattern_number, o_found, o_table_overflow,
                                 o_last_of_report, msg))
                report(msg);
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // one transaction; pauses fall at the falling edge only
    task automatic send(t_cmd cmd, int unsigned ltr);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_letter  <= ltr[LTR_W-1:0];
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, ltr);
        items++;
        @(negedge i_clk);
    endtask

    task automatic send_pattern(string s);
        foreach (s[i]) send(CMD_PAT_LTR, s[i] - "a");
        send(CMD_PAT_END, $urandom_range(31));
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send(CMD_TEXT_LTR, s[i] - "a");
    endtask

    task automatic random_job();
        int np, len, tl, span;
        span = ($urandom_range(3) == 0) ? 26 : 4;
        np = $urandom_range(7);
        for (int p = 0; p < np; p++) begin
            len = $urandom_range(4);
            for (int k = 0; k < len; k++)
                send(CMD_PAT_LTR, ($urandom_range(15) == 0) ? $urandom_range(31)
                                                            : $urandom_range(span - 1));
            if ($urandom_range(9) != 0) send(CMD_PAT_END, $urandom_range(31));
        end
        tl = $urandom_range(16);
        for (int k = 0; k < tl; k++) begin
            if ($urandom_range(11) == 0) send(t_cmd'($urandom_range(1)), $urandom_range(31));
            else send(CMD_TEXT_LTR, ($urandom_range(15) == 0) ? $urandom_range(31)
                                                           : $urandom_range(span - 1));
        end
        send(CMD_TEXT_END, $urandom_range(31));
    endtask

    initial begin
        sb = new();
        sb.clear_trie();
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_command = '0;
        i_letter  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // overlapping patterns, empty pattern, out-of-range letters
        send_pattern("a");
        send_pattern("ab");
        send_pattern("bab");
        send_pattern("");
        send_pattern("z");
        send(CMD_PAT_LTR, 27);
        send_pattern("zq");
        send_text("xbab");
        send(CMD_TEXT_LTR, 31);
        send(CMD_PAT_END, 0);
        send_text("zq");
        send(CMD_TEXT_END, 0);
        // no patterns at all
        send_text("ab");
        send(CMD_TEXT_END, 31);
        // empty text with an unfinished pattern left over
        send_pattern("cd");
        send(CMD_PAT_LTR, 4);
        send(CMD_TEXT_END, 0);
        // pattern table overflow
        for (int i = 0; i < MAX_PATTERNS + 2; i++) send(CMD_PAT_END, 0);
        send(CMD_TEXT_END, 0);
        // node table overflow on one long path
        for (int i = 0; i < MAX_NODES + 8; i++) send(CMD_PAT_LTR, i % 26);
        send(CMD_PAT_END, 0);
        send_pattern("abc");
        send_text("abcd");
        send(CMD_TEXT_END, 0);

        items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 87; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 87; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            while (items < (ph + 1) * 58) random_job();
        end
        i_valid <= 1'b0;

        while (sb.pending_flags.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
